/* src/bfth_pkg.sv */
package bfth_pkg;

    typedef logic [31:0] word_t;

    // hash start values and multipliers
    localparam word_t FNV_START  = 32'd2166136261;
    localparam word_t FNV_PRIME  = 32'd16777619;
    localparam word_t SX_START   = 32'h5bd1e995;
    localparam word_t POLY_START = 32'h811c9dc5;
    localparam word_t POLY_MULT  = 32'd31;
    localparam int    SX_SHIFT   = 5;

    // store row: 32 filter bits per memory word
    localparam int ROW_BITS = 5;
    localparam int ROW_W    = 1 << ROW_BITS;

    // result packing in m_tdata
    localparam int COUNT_OUT_W = 17;
    localparam int OUT_W       = 24;

    typedef logic [ROW_W-1:0] row_t;

    function automatic word_t sext_byte(input logic [7:0] b);
        sext_byte = {{24{b[7]}}, b};
    endfunction

    function automatic word_t fnv_step(input word_t h, input logic [7:0] b);
        word_t x;
        x = h ^ {24'd0, b};
        fnv_step = x * FNV_PRIME;
    endfunction

    function automatic word_t sx_step(input word_t h, input logic [7:0] b);
        sx_step = ((h << SX_SHIFT) + h) ^ sext_byte(b);
    endfunction

    function automatic word_t poly_step(input word_t h, input logic [7:0] b);
        poly_step = (h * POLY_MULT) + sext_byte(b);
    endfunction

endpackage

/* src/bfth_hash.sv */
module bfth_hash #(
    parameter int INDEX_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  restart,
    input  logic [7:0]            key_byte,
    output logic [INDEX_BITS-1:0] idx_next [3]
);

    bfth_pkg::word_t fnv_reg, fnv_next;
    bfth_pkg::word_t sx_reg, sx_next;
    bfth_pkg::word_t poly_reg, poly_next;

    assign fnv_next  = bfth_pkg::fnv_step(fnv_reg, key_byte);
    assign sx_next   = bfth_pkg::sx_step(sx_reg, key_byte);
    assign poly_next = bfth_pkg::poly_step(poly_reg, key_byte);

    assign idx_next[0] = fnv_next[INDEX_BITS-1:0];
    assign idx_next[1] = sx_next[INDEX_BITS-1:0];
    assign idx_next[2] = poly_next[INDEX_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fnv_reg  <= bfth_pkg::FNV_START;
            sx_reg   <= bfth_pkg::SX_START;
            poly_reg <= bfth_pkg::POLY_START;
        end else if (advance) begin
            if (restart) begin
                // key done: start over for the next one
                fnv_reg  <= bfth_pkg::FNV_START;
                sx_reg   <= bfth_pkg::SX_START;
                poly_reg <= bfth_pkg::POLY_START;
            end else begin
                fnv_reg  <= fnv_next;
                sx_reg   <= sx_next;
                poly_reg <= poly_next;
            end
        end
    end

endmodule

/* src/bfth_store.sv */
module bfth_store #(
    parameter int ROW_AW = 11
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ROW_AW-1:0]   wr_addr,
    input  bfth_pkg::row_t      wr_data,
    input  logic [ROW_AW-1:0]   rd_addr,
    output bfth_pkg::row_t      rd_data
);

    localparam int DEPTH = 1 << ROW_AW;

    bfth_pkg::row_t mem [DEPTH];
    bfth_pkg::row_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/bloom_filter_three_hash_core.sv */
// Bytes that are not last are taken one per cycle.
// A last byte runs three read-modify-write passes, a read state then a modify
// state each, on the bit store, then the done state loads the result register
// once the output is free.
// After reset the store is swept to zero, one 32-bit row a cycle, over all
// 2^(INDEX_BITS-5) rows with s_tready low.
module bloom_filter_three_hash_core #(
    parameter int INDEX_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_byte
    input  logic [0:0]  s_tuser,   // [0] cmd
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] maybe_present, [17:1] set_bit_count, [18] half_full
);

    localparam int ROW_AW = INDEX_BITS - bfth_pkg::ROW_BITS;
    localparam int CNT_W  = INDEX_BITS + 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_RUN    = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_MODIFY = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic [1:0] OP_LAST = 2'd2;

    logic [2:0]                 state_reg, state_next;
    logic [ROW_AW-1:0]          clr_row_reg, clr_row_next;
    logic [INDEX_BITS-1:0]      idx_reg [3];
    logic [1:0]                 op_reg, op_next;
    logic                       query_reg;
    logic                       present_reg, present_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       out_valid_reg;
    logic [bfth_pkg::OUT_W-1:0] out_data_reg;

    logic                  s_accept;
    logic                  key_end;
    logic [INDEX_BITS-1:0] hash_idx [3];
    logic [INDEX_BITS-1:0] cur_idx;
    logic [ROW_AW-1:0]     cur_row;
    logic [bfth_pkg::ROW_BITS-1:0] cur_col;
    bfth_pkg::row_t        rd_data;
    bfth_pkg::row_t        wr_data;
    logic [ROW_AW-1:0]     wr_addr;
    logic                  wr_en;
    logic                  bit_hit;
    logic                  out_free;
    logic                  half_full;
    logic [31:0]           count_ext;

    assign s_tready = (state_reg == ST_RUN);
    assign s_accept = s_tvalid && s_tready;
    assign key_end  = s_accept && s_tlast;
    assign out_free = !out_valid_reg || m_tready;

    bfth_hash #(
        .INDEX_BITS(INDEX_BITS)
    ) u_hash (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (s_accept),
        .restart  (s_tlast),
        .key_byte (s_tdata),
        .idx_next (hash_idx)
    );

    assign cur_idx = idx_reg[op_reg];
    assign cur_row = cur_idx[INDEX_BITS-1:bfth_pkg::ROW_BITS];
    assign cur_col = cur_idx[bfth_pkg::ROW_BITS-1:0];
    assign bit_hit = rd_data[cur_col];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_row;
        wr_data = rd_data | (bfth_pkg::row_t'(1) << cur_col);
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_row_reg;
            wr_data = '0;
        end else if (state_reg == ST_MODIFY) begin
            wr_en = !query_reg && !bit_hit;
        end
    end

    bfth_store #(
        .ROW_AW(ROW_AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (cur_row),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        clr_row_next = clr_row_reg;
        op_next      = op_reg;
        present_next = present_reg;
        count_next   = count_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == '1) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (key_end) begin
                    op_next      = 2'd0;
                    // an add reports 0; a query starts true and ANDs each bit
                    present_next = s_tuser[0];
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                present_next = present_reg && bit_hit;
                if (!query_reg && !bit_hit) begin
                    count_next = count_reg + 1'b1;
                end
                if (op_reg == OP_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    op_next    = op_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign count_ext = 32'(count_reg);
    assign half_full = (count_reg[CNT_W-1:CNT_W-2] != 2'b00);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            op_reg        <= '0;
            present_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_row_reg <= clr_row_next;
            op_reg      <= op_next;
            present_reg <= present_next;
            count_reg   <= count_next;
            if (state_reg == ST_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (key_end) begin
            idx_reg[0] <= hash_idx[0];
            idx_reg[1] <= hash_idx[1];
            idx_reg[2] <= hash_idx[2];
            query_reg  <= s_tuser[0];
        end
        if (state_reg == ST_DONE && out_free) begin
            out_data_reg <= {5'd0, half_full, count_ext[bfth_pkg::COUNT_OUT_W-1:0],
                             present_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* src/bfth_checker.sv */
module bfth_checker #(
    parameter int INDEX_BITS = 16
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    localparam logic [16:0] HALF = 17'(1) << (INDEX_BITS - 1);
    localparam bit SMALL = (INDEX_BITS <= 16);

    logic [16:0] prev_count_reg;
    logic [16:0] out_count;

    assign out_count = m_tdata[17:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_count_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            prev_count_reg <= out_count;
        end
    end

    // hold both sides off while in reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("handshake active after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // the store update after a key end blocks the input
    a_key_end_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during store update");

    a_half_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && SMALL |-> m_tdata[18] == (out_count >= HALF))
        else $error("half_full disagrees with count");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && SMALL |-> out_count >= prev_count_reg)
        else $error("set bit count went down");

endmodule

bind bloom_filter_three_hash_core bfth_checker #(
    .INDEX_BITS(INDEX_BITS)
) u_bfth_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
